FILE: rtl/core/kvi_pkg.sv
// ----------------------------------------------------------------------------
// kvi_pkg
// shared widths, codes and types of the keyframe vector interpolator
// ----------------------------------------------------------------------------
package kvi_pkg;

  localparam int TIME_W   = 24;
  localparam int VAL_W    = 32;
  localparam int NUM_COMP = 3;
  localparam int VEC_W    = VAL_W * NUM_COMP;
  localparam int FRAC_W   = 16;
  localparam int SLOT_W   = 6;
  localparam int CNT_W    = 7;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] key_time;
    logic [VEC_W-1:0]  key_val;
  } kvi_wr_t;

endpackage

FILE: rtl/core/kvi_key_mem.sv
// ----------------------------------------------------------------------------
// kvi_key_mem
// key time and key vector memories, one write port, one registered read each
// ----------------------------------------------------------------------------
module kvi_key_mem #(
  parameter int MAX_KEYS = 64
) (
  input  logic                         clk,
  input  kvi_pkg::kvi_wr_t             wr,
  input  logic [$clog2(MAX_KEYS)-1:0]  t_raddr,
  input  logic [$clog2(MAX_KEYS)-1:0]  v_raddr,
  output logic [kvi_pkg::TIME_W-1:0]   t_rdata,
  output logic [kvi_pkg::VEC_W-1:0]    v_rdata
);

  localparam int AW = $clog2(MAX_KEYS);

  logic [kvi_pkg::TIME_W-1:0] time_mem [MAX_KEYS];
  logic [kvi_pkg::VEC_W-1:0]  val_mem  [MAX_KEYS];
  logic [kvi_pkg::TIME_W-1:0] t_rdata_r;
  logic [kvi_pkg::VEC_W-1:0]  v_rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      time_mem[AW'(wr.slot)] <= wr.key_time;
    end
    t_rdata_r <= time_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      val_mem[AW'(wr.slot)] <= wr.key_val;
    end
    v_rdata_r <= val_mem[v_raddr];
  end

  assign t_rdata = t_rdata_r;
  assign v_rdata = v_rdata_r;

endmodule

FILE: rtl/core/kvi_div.sv
// ----------------------------------------------------------------------------
// kvi_div
// restoring divider for the blend factor, one quotient bit per cycle
// ----------------------------------------------------------------------------
module kvi_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [kvi_pkg::TIME_W-1:0]  num,
  input  logic [kvi_pkg::TIME_W-1:0]  den,
  output logic [kvi_pkg::FRAC_W-1:0]  quo,
  output logic                        done
);

  localparam int TW = kvi_pkg::TIME_W;
  localparam int FW = kvi_pkg::FRAC_W;
  localparam int KW = $clog2(FW + 1);

  logic [TW-1:0] rem_r, rem_nxt;
  logic [TW-1:0] den_r, den_nxt;
  logic [FW-1:0] quo_r, quo_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [TW:0]   sh;
  logic [TW:0]   sub;
  logic          geq;

  assign sh  = {rem_r, 1'b0};
  assign sub = sh - {1'b0, den_r};
  assign geq = sh >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = num;
      den_nxt  = den;
      quo_nxt  = '0;
      cnt_nxt  = KW'(FW);
      run_nxt  = 1'b1;
      done_nxt = 1'b0;
    end else if (run_r) begin
      rem_nxt = geq ? sub[TW-1:0] : sh[TW-1:0];
      quo_nxt = {quo_r[FW-2:0], geq};
      cnt_nxt = cnt_r - KW'(1);
      if (cnt_r == KW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

FILE: rtl/core/kvi_blend.sv
// ----------------------------------------------------------------------------
// kvi_blend
// linear blend a + floor((b - a) * f / 2^16), one shared multiplier,
// components in turn
// ----------------------------------------------------------------------------
module kvi_blend (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [kvi_pkg::FRAC_W-1:0]  f,
  input  logic [kvi_pkg::VEC_W-1:0]   a,
  input  logic [kvi_pkg::VEC_W-1:0]   b,
  output logic [kvi_pkg::VEC_W-1:0]   res,
  output logic                        done
);

  localparam int VW = kvi_pkg::VAL_W;
  localparam int FW = kvi_pkg::FRAC_W;
  localparam int PW = VW + FW + 2;
  localparam int NC = kvi_pkg::NUM_COMP;

  logic                 run_r, run_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 pv_r;
  logic [1:0]           pidx_r;
  logic signed [PW-1:0] prod_r;
  logic [kvi_pkg::VEC_W-1:0] res_r;
  logic                 done_r;
  logic signed [VW-1:0] a_c;
  logic signed [VW-1:0] b_c;
  logic signed [VW:0]   diff;
  logic signed [FW:0]   f_s;
  logic [VW-1:0]        pa_c;

  assign a_c  = a[VW*cnt_r +: VW];
  assign b_c  = b[VW*cnt_r +: VW];
  assign diff = (VW+1)'(b_c) - (VW+1)'(a_c);
  assign f_s  = $signed({1'b0, f});
  assign pa_c = a[VW*pidx_r +: VW];

  always_comb begin
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (run_r) begin
      cnt_nxt = cnt_r + 2'd1;
      if (cnt_r == 2'(NC - 1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      cnt_r  <= '0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      cnt_r  <= cnt_nxt;
      pv_r   <= run_r && !start;
      done_r <= pv_r && (pidx_r == 2'(NC - 1));
    end
  end

  always_ff @(posedge clk) begin
    pidx_r <= cnt_r;
    prod_r <= diff * f_s;
    if (pv_r) begin
      res_r[VW*pidx_r +: VW] <= pa_c + prod_r[FW +: VW];
    end
  end

  assign res  = res_r;
  assign done = done_r;

endmodule

FILE: rtl/core/keyframe_vector_interpolator_top.sv
// timing: a load does not make the block busy; a blending query stays busy through
// the linear key search (one key time per cycle), the factor divider and the
// shared 3-component multiplier; a stored-key result, also at or past the last key
// and with a single key, skips the divider and multiplier; it strobes once busy falls
// throughput: one query in flight, busy until its result strobes; no output stall
// reset: synchronous active low, clears control, key_count to 1; key memories not cleared
// ----------------------------------------------------------------------------
// keyframe_vector_interpolator_top
// samples a track of 3-component keys by linear interpolation between keys
// ----------------------------------------------------------------------------
module keyframe_vector_interpolator_top #(
  parameter int MAX_KEYS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_action,
  input  logic [kvi_pkg::SLOT_W-1:0]         in_key_slot,
  input  logic [kvi_pkg::TIME_W-1:0]         in_key_time,
  input  logic signed [kvi_pkg::VAL_W-1:0]   in_value_x,
  input  logic signed [kvi_pkg::VAL_W-1:0]   in_value_y,
  input  logic signed [kvi_pkg::VAL_W-1:0]   in_value_z,
  input  logic [kvi_pkg::TIME_W-1:0]         in_query_time,
  input  logic                               cfg_we,
  input  logic [kvi_pkg::CNT_W-1:0]          cfg_wdata,
  output logic                               out_valid,
  output logic signed [kvi_pkg::VAL_W-1:0]   out_x,
  output logic signed [kvi_pkg::VAL_W-1:0]   out_y,
  output logic signed [kvi_pkg::VAL_W-1:0]   out_z,
  output logic [kvi_pkg::SLOT_W-1:0]         out_lower_key,
  output logic                               out_clamped
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int XW = (CW > kvi_pkg::CNT_W) ? CW : kvi_pkg::CNT_W;
  localparam int TW = kvi_pkg::TIME_W;
  localparam int VW = kvi_pkg::VAL_W;
  localparam int SW = kvi_pkg::SLOT_W;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_SEARCH = 11'b00000000010,
    S_T1RD   = 11'b00000000100,
    S_T1CHK  = 11'b00000001000,
    S_VA     = 11'b00000010000,
    S_VB     = 11'b00000100000,
    S_VW     = 11'b00001000000,
    S_DIV    = 11'b00010000000,
    S_BLEND  = 11'b00100000000,
    S_KEYRD  = 11'b01000000000,
    S_KEYOUT = 11'b10000000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [kvi_pkg::CNT_W-1:0]  key_count_r;
  logic [TW-1:0]              qt_r, qt_nxt;
  logic [CW-1:0]              n_r, n_nxt;
  logic [CW-1:0]              j_r, j_nxt;
  logic                       cmp_v_r, cmp_v_nxt;
  logic [CW-1:0]              cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]              lo_r, lo_nxt;
  logic [AW-1:0]              key_r, key_nxt;
  logic [TW-1:0]              t2_r, t2_nxt;
  logic                       clamped_r, clamped_nxt;
  logic [kvi_pkg::VEC_W-1:0]  a_r, a_nxt;
  logic [kvi_pkg::VEC_W-1:0]  b_r, b_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [kvi_pkg::VEC_W-1:0]  out_vec_r, out_vec_nxt;
  logic [SW-1:0]              out_lo_r, out_lo_nxt;
  logic                       out_cl_r, out_cl_nxt;

  logic [XW-1:0]              kc_ext;
  logic [CW-1:0]              n_sel;
  logic                       accept;
  logic                       slot_ok;
  kvi_pkg::kvi_wr_t           wr;
  logic [AW-1:0]              t_raddr;
  logic [AW-1:0]              v_raddr;
  logic [TW-1:0]              t_rdata;
  logic [kvi_pkg::VEC_W-1:0]  v_rdata;
  logic                       div_start;
  logic [kvi_pkg::FRAC_W-1:0] div_quo;
  logic                       div_done;
  logic                       blend_start;
  logic [kvi_pkg::VEC_W-1:0]  blend_res;
  logic                       blend_done;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // active key count, zero acts as one and large values saturate
  assign kc_ext = XW'(key_count_r);
  always_comb begin
    if (key_count_r == '0) begin
      n_sel = CW'(1);
    end else if (kc_ext > XW'(MAX_KEYS)) begin
      n_sel = CW'(MAX_KEYS);
    end else begin
      n_sel = CW'(kc_ext);
    end
  end

  assign slot_ok     = XW'(in_key_slot) < XW'(MAX_KEYS);
  assign wr.en       = accept && (in_action == kvi_pkg::ACT_LOAD) && slot_ok;
  assign wr.slot     = in_key_slot;
  assign wr.key_time = in_key_time;
  assign wr.key_val  = {in_value_z, in_value_y, in_value_x};

  // loads are written only while idle, so reads never overlap a write
  always_comb begin
    case (state_r)
      S_T1RD:  t_raddr = lo_r;
      default: t_raddr = j_r[AW-1:0];
    endcase
  end

  always_comb begin
    case (state_r)
      S_VA:    v_raddr = lo_r;
      S_VB:    v_raddr = lo_r + AW'(1);
      default: v_raddr = key_r;
    endcase
  end

  kvi_key_mem #(
    .MAX_KEYS (MAX_KEYS)
  ) u_mem (
    .clk     (clk),
    .wr      (wr),
    .t_raddr (t_raddr),
    .v_raddr (v_raddr),
    .t_rdata (t_rdata),
    .v_rdata (v_rdata)
  );

  assign div_start = (state_r == S_T1CHK) && !(qt_r < t_rdata) && (t2_r > t_rdata);

  kvi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (qt_r - t_rdata),
    .den   (t2_r - t_rdata),
    .quo   (div_quo),
    .done  (div_done)
  );

  assign blend_start = (state_r == S_DIV) && div_done;

  kvi_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .start (blend_start),
    .f     (div_quo),
    .a     (a_r),
    .b     (b_r),
    .res   (blend_res),
    .done  (blend_done)
  );

  always_comb begin
    state_nxt     = state_r;
    qt_nxt        = qt_r;
    n_nxt         = n_r;
    j_nxt         = j_r;
    cmp_v_nxt     = cmp_v_r;
    cmp_idx_nxt   = cmp_idx_r;
    lo_nxt        = lo_r;
    key_nxt       = key_r;
    t2_nxt        = t2_r;
    clamped_nxt   = clamped_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    out_valid_nxt = 1'b0;
    out_vec_nxt   = out_vec_r;
    out_lo_nxt    = out_lo_r;
    out_cl_nxt    = out_cl_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_action == kvi_pkg::ACT_QUERY)) begin
          qt_nxt = in_query_time;
          n_nxt  = n_sel;
          if (n_sel == CW'(1)) begin
            lo_nxt      = '0;
            key_nxt     = '0;
            clamped_nxt = 1'b0;
            state_nxt   = S_KEYRD;
          end else begin
            j_nxt     = CW'(1);
            cmp_v_nxt = 1'b0;
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        j_nxt       = j_r + CW'(1);
        cmp_v_nxt   = 1'b1;
        cmp_idx_nxt = j_r;
        if (cmp_v_r) begin
          if (qt_r < t_rdata) begin
            lo_nxt    = AW'(cmp_idx_r - CW'(1));
            t2_nxt    = t_rdata;
            state_nxt = S_T1RD;
          end else if (cmp_idx_r == n_r - CW'(1)) begin
            // at or past the last key
            lo_nxt      = AW'(n_r - CW'(2));
            key_nxt     = AW'(n_r - CW'(1));
            clamped_nxt = qt_r > t_rdata;
            state_nxt   = S_KEYRD;
          end
        end
      end
      S_T1RD: begin
        state_nxt = S_T1CHK;
      end
      S_T1CHK: begin
        key_nxt     = lo_r;
        clamped_nxt = qt_r < t_rdata;
        if (div_start) begin
          state_nxt = S_VA;
        end else begin
          state_nxt = S_KEYRD;
        end
      end
      S_VA: begin
        state_nxt = S_VB;
      end
      S_VB: begin
        a_nxt     = v_rdata;
        state_nxt = S_VW;
      end
      S_VW: begin
        b_nxt     = v_rdata;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_BLEND;
        end
      end
      S_BLEND: begin
        if (blend_done) begin
          out_valid_nxt = 1'b1;
          out_vec_nxt   = blend_res;
          out_lo_nxt    = SW'(lo_r);
          out_cl_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      S_KEYRD: begin
        state_nxt = S_KEYOUT;
      end
      S_KEYOUT: begin
        out_valid_nxt = 1'b1;
        out_vec_nxt   = v_rdata;
        out_lo_nxt    = SW'(lo_r);
        out_cl_nxt    = clamped_r;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_count_r <= kvi_pkg::CNT_W'(1);
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_v_r     <= cmp_v_nxt;
      if (cfg_we) begin
        key_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    qt_r      <= qt_nxt;
    n_r       <= n_nxt;
    j_r       <= j_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    lo_r      <= lo_nxt;
    key_r     <= key_nxt;
    t2_r      <= t2_nxt;
    clamped_r <= clamped_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    out_vec_r <= out_vec_nxt;
    out_lo_r  <= out_lo_nxt;
    out_cl_r  <= out_cl_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_x         = out_vec_r[0*VW +: VW];
  assign out_y         = out_vec_r[1*VW +: VW];
  assign out_z         = out_vec_r[2*VW +: VW];
  assign out_lower_key = out_lo_r;
  assign out_clamped   = out_cl_r;

endmodule

FILE: rtl/core/kvi_checker.sv
// ----------------------------------------------------------------------------
// kvi_checker
// port-level checks of the keyframe vector interpolator
// ----------------------------------------------------------------------------
module kvi_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_action,
  input logic out_valid
);

  // a load beat completes at once
  a_load_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == kvi_pkg::ACT_LOAD)) |=> !busy)
    else $error("load beat left the block busy");

  // a query beat always occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == kvi_pkg::ACT_QUERY)) |=> busy)
    else $error("query beat did not make the block busy");

  // a result strobe marks the end of the query
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while still busy");

  // one result per query, never back to back
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // busy only rises on an accepted beat
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

endmodule

bind keyframe_vector_interpolator_top kvi_checker u_kvi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_action (in_action),
  .out_valid (out_valid)
);
